// ===== sv/sorted_coalescing_free_list_core_assert.svh =====
// Assertion macros for the sorted coalescing free list.
// Used by the checker module; expects clk and rst in the scope of each use.
`ifndef SORTED_COALESCING_FREE_LIST_CORE_ASSERT_SVH
`define SORTED_COALESCING_FREE_LIST_CORE_ASSERT_SVH

// Ordinary check, switched off while reset is held.
`define SCFL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scfl check failed");

// Check that also runs through reset.
`define SCFL_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scfl reset check failed");

`endif

// ===== sv/scfl_pkg.sv =====
// Shared types and codes of the sorted coalescing free list.
// No dependencies; imported by scfl_alu and the top level.
package scfl_pkg;

  // Request action codes.
  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Compare flags of the shared unit against its result.
  typedef struct packed {
    logic lt;
    logic eq;
  } scfl_flags_t;

endpackage

// ===== sv/scfl_if.sv =====
// Request and response channel interfaces of the free list.
// Valid/ready handshake; depends on nothing.
interface scfl_req_if #(
  parameter int ADDR_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [ADDR_BITS-1:0] block_end;
  logic [ADDR_BITS-1:0] block_size;
  logic [ADDR_BITS-1:0] arena_top;

  modport source (output valid, action, block_end, block_size, arena_top, input ready);
  modport sink (input valid, action, block_end, block_size, arena_top, output ready);
endinterface

interface scfl_rsp_if #(
  parameter int ADDR_BITS = 32,
  parameter int CNT_BITS  = 5
);
  logic                 valid;
  logic                 ready;
  logic                 released;
  logic [ADDR_BITS-1:0] new_top;
  logic [CNT_BITS-1:0]  pending_count;
  logic                 overflow_error;

  modport source (output valid, released, new_top, pending_count, overflow_error,
                  input ready);
  modport sink (input valid, released, new_top, pending_count, overflow_error,
                output ready);
endinterface

// ===== sv/scfl_alu.sv =====
// Shared add/subtract unit with a compare against its result.
// Depends on scfl_pkg.
module scfl_alu
  import scfl_pkg::*;
#(
  parameter int W = 32
) (
  input  alu_op_t     op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] c,
  output logic [W-1:0] res,
  output scfl_flags_t  flags
);

  always_comb begin
    unique case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a - b;
    endcase
    flags.lt = (c < res);
    flags.eq = (c == res);
  end

endmodule

// ===== sv/scfl_mem.sv =====
// Entry store of the free list: one write port, one registered read port.
// Depends on nothing; it does not import scfl_pkg.
module scfl_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sorted_coalescing_free_list_core.sv =====
// Sorted coalescing free list for a stack allocator: top level.
// Depends on scfl_pkg, scfl_if, scfl_alu and scfl_mem.
//
// The block keeps the freed blocks that cannot yet go back to the arena,
// sorted by address, each as an end address and a size. A request on req
// either adds a block (action 0), merging it with touching neighbours, or
// tries to release the topmost pending block against arena_top (action 1).
// Every request gives exactly one response on rsp: released, new_top, the
// pending count afterwards and an overflow flag when a full list refused
// an insert. Both channels use a valid/ready handshake.
// Requests are handled one at a time by a sequencer around one shared
// adder/subtractor and a one-read, one-write entry memory. A release goes
// through S_REL to S_DONE (straight to S_DONE on an empty list); an add
// goes through S_PREP, S_SCAN for each entry scanned, a state per merge
// step and entry shifted, then S_DONE. req.ready is high only while the
// sequencer is idle, so the next request is taken in the cycle after the
// response is set up. The response sits in an output register, so the
// next request is accepted while it waits; if the receiver stalls longer,
// the following response waits in the sequencer. Synchronous reset empties
// the list at once; the entry memory itself is not cleared.
module sorted_coalescing_free_list_core
  import scfl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  scfl_req_if.sink   req,
  scfl_rsp_if.source rsp
);

  localparam int IW       = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int W        = ADDR_BITS;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_MB,
    S_MA,
    S_SHUP,
    S_INS,
    S_FOLD_CHK,
    S_FOLD,
    S_SHDN,
    S_REL,
    S_DONE
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] count;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       k;
  logic [W-1:0]        cur_end;
  logic [W-1:0]        cur_size;
  logic [W-1:0]        cur_beg;
  logic [W-1:0]        cur_top;
  logic [W-1:0]        m_end;
  logic [W-1:0]        m_size;
  logic                res_released;
  logic [W-1:0]        res_new_top;
  logic                res_ovf;

  logic                out_valid;
  logic                out_released;
  logic [W-1:0]        out_new_top;
  logic [CNT_BITS-1:0] out_count;
  logic                out_ovf;

  // Memory port and shared unit controls.
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [2*W-1:0]  rd_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [2*W-1:0]  wr_data;
  alu_op_t         alu_op;
  logic [W-1:0]    alu_a;
  logic [W-1:0]    alu_b;
  logic [W-1:0]    alu_c;
  logic [W-1:0]    alu_res;
  scfl_flags_t     alu_flags;

  logic [W-1:0]    rd_end;
  logic [W-1:0]    rd_size;
  logic [IW-1:0]   last;
  logic            next_ok;
  logic            fold_more;
  logic            full;
  logic            touch_after;

  assign rd_end      = rd_data[2*W-1:W];
  assign rd_size     = rd_data[W-1:0];
  assign last        = IW'(count - CNT_BITS'(1));
  assign next_ok     = (CNT_BITS'(idx) + CNT_BITS'(1)) < count;
  assign fold_more   = (CNT_BITS'(idx) + CNT_BITS'(2)) < count;
  assign full        = (count == CNT_BITS'(MAX_ENTRIES));
  assign touch_after = (cur_beg == rd_end);

  scfl_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (2 * W),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scfl_alu #(
    .W (W)
  ) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .c     (alu_c),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // Memory and shared unit steering. By default the unit works out the
  // begin address of the entry just read and compares the new block's end
  // against it.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {cur_end, cur_size};
    alu_op  = ALU_SUB;
    alu_a   = rd_end;
    alu_b   = rd_size;
    alu_c   = cur_end;
    unique case (state)
      S_IDLE: begin
        // Fetch the topmost entry early for a release.
        rd_en   = req.valid && (req.action == ACT_RELEASE);
        rd_addr = last;
      end
      S_PREP: begin
        alu_a = cur_end;
        alu_b = cur_size;
        if (count == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SCAN: begin
        priority if (alu_flags.lt) begin
          // Insert here: start moving entries up from the top.
          rd_en   = !full;
          rd_addr = last;
        end else if (alu_flags.eq || touch_after) begin
          // Merge handled in the next state with the entry still held.
        end else if (next_ok) begin
          rd_en   = 1'b1;
          rd_addr = idx + IW'(1);
        end else begin
          // Past every entry: append at the end.
          wr_en   = !full;
          wr_addr = IW'(count);
        end
      end
      S_MB: begin
        alu_op  = ALU_ADD;
        alu_a   = rd_size;
        alu_b   = cur_size;
        wr_en   = 1'b1;
        wr_data = {rd_end, alu_res};
      end
      S_MA: begin
        alu_op  = ALU_ADD;
        alu_a   = rd_size;
        alu_b   = cur_size;
        wr_en   = 1'b1;
        wr_data = {cur_end, alu_res};
        rd_en   = next_ok;
        rd_addr = idx + IW'(1);
      end
      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = k + IW'(1);
        wr_data = rd_data;
        rd_en   = (k != idx);
        rd_addr = k - IW'(1);
      end
      S_INS: begin
        wr_en = 1'b1;
      end
      S_FOLD_CHK: begin
        alu_c = m_end;
      end
      S_FOLD: begin
        alu_op  = ALU_ADD;
        alu_a   = m_size;
        alu_b   = rd_size;
        wr_en   = 1'b1;
        wr_data = {rd_end, alu_res};
        rd_en   = fold_more;
        rd_addr = idx + IW'(2);
      end
      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = k - IW'(1);
        wr_data = rd_data;
        rd_en   = (CNT_BITS'(k) < count);
        rd_addr = k + IW'(1);
      end
      S_REL: begin
        alu_a = cur_top;
        alu_b = rd_size;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, list count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the done state the response register is reloaded instead.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_end      <= req.block_end;
            cur_size     <= req.block_size;
            cur_top      <= req.arena_top;
            res_released <= 1'b0;
            res_new_top  <= req.arena_top;
            res_ovf      <= 1'b0;
            idx          <= '0;
            if (req.action == ACT_RELEASE) begin
              state <= (count == '0) ? S_DONE : S_REL;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          cur_beg <= alu_res;
          if (count == '0) begin
            count <= count + CNT_BITS'(1);
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (alu_flags.lt) begin
            if (full) begin
              res_ovf <= 1'b1;
              state   <= S_DONE;
            end else begin
              k     <= last;
              state <= S_SHUP;
            end
          end else if (alu_flags.eq) begin
            state <= S_MB;
          end else if (touch_after) begin
            state <= S_MA;
          end else if (next_ok) begin
            idx <= idx + IW'(1);
          end else if (full) begin
            res_ovf <= 1'b1;
            state   <= S_DONE;
          end else begin
            count <= count + CNT_BITS'(1);
            state <= S_DONE;
          end
        end
        S_MB: begin
          state <= S_DONE;
        end
        S_MA: begin
          m_end  <= cur_end;
          m_size <= alu_res;
          state  <= next_ok ? S_FOLD_CHK : S_DONE;
        end
        S_SHUP: begin
          if (k == idx) begin
            state <= S_INS;
          end else begin
            k <= k - IW'(1);
          end
        end
        S_INS: begin
          count <= count + CNT_BITS'(1);
          state <= S_DONE;
        end
        S_FOLD_CHK: begin
          // Fold the following entry in when the gap has closed.
          state <= alu_flags.eq ? S_FOLD : S_DONE;
        end
        S_FOLD: begin
          count <= count - CNT_BITS'(1);
          if (fold_more) begin
            k     <= idx + IW'(2);
            state <= S_SHDN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHDN: begin
          if (CNT_BITS'(k) < count) begin
            k <= k + IW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_REL: begin
          if (rd_end == cur_top) begin
            res_released <= 1'b1;
            res_new_top  <= alu_res;
            count        <= count - CNT_BITS'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid    <= 1'b1;
            out_released <= res_released;
            out_new_top  <= res_new_top;
            out_count    <= count;
            out_ovf      <= res_ovf;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.released       = out_released;
  assign rsp.new_top        = out_new_top;
  assign rsp.pending_count  = out_count;
  assign rsp.overflow_error = out_ovf;

endmodule

// ===== sv/scfl_checker.sv =====
// Port-level checks of the free list and the bind that attaches them.
// Depends on sorted_coalescing_free_list_core_assert.svh.
`include "sorted_coalescing_free_list_core_assert.svh"

module scfl_checker #(
  parameter int MAX_ENTRIES = 16,
  parameter int CNT_BITS    = 5
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic                released,
  input logic                overflow_error,
  input logic [CNT_BITS-1:0] pending_count
);

  `SCFL_ASSERT_RST(a_reset_clears, rst |=> !rsp_valid && req_ready)
  `SCFL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(pending_count))
  `SCFL_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready)
  `SCFL_ASSERT(a_flags_exclusive, rsp_valid |-> !(released && overflow_error))
  `SCFL_ASSERT(a_count_bound, rsp_valid |-> pending_count <= CNT_BITS'(MAX_ENTRIES))

endmodule

bind sorted_coalescing_free_list_core scfl_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .CNT_BITS    (CNT_BITS)
) u_scfl_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .released       (rsp.released),
  .overflow_error (rsp.overflow_error),
  .pending_count  (rsp.pending_count)
);
